[design/rclr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-count load rebalancer package
// Shared widths, register indexes, reset values, sequencer states and the
// control group passed to the count store.
// ----------------------------------------------------------------------------
package rclr_pkg;

   localparam int DEF_MAX_WORKERS  = 16;
   localparam int DEF_COUNT_BITS   = 32;

   localparam int WORKER_BITS      = 4;
   localparam int NUM_WORKERS_BITS = 5;
   localparam int PERIOD_BITS      = 16;
   localparam int RATIO_BITS       = 16;
   localparam int RATIO_FRAC_BITS  = 8;
   localparam int CSR_DATA_BITS    = 16;
   localparam int CSR_INDEX_BITS   = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_WORKERS  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROUND_PERIOD = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIFF_RATIO   = 2'd2;

   localparam logic [NUM_WORKERS_BITS-1:0] NUM_WORKERS_RESET = 5'd2;
   localparam logic [NUM_WORKERS_BITS-1:0] MIN_WORKERS       = 5'd2;
   localparam logic [NUM_WORKERS_BITS-1:0] LIMIT_WORKERS     = 5'd16;
   localparam logic [PERIOD_BITS-1:0]      ROUND_PERIOD_RESET = 16'd0;
   localparam logic [RATIO_BITS-1:0]       DIFF_RATIO_RESET   = 16'd256;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INC,
      ST_LOAD,
      ST_SORT,
      ST_FILL,
      ST_PAIR,
      ST_MUL,
      ST_DECIDE,
      ST_FLUSH,
      ST_UNROT
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic clr_en;
      logic clr_bank;
   } store_ctl_type;

endpackage

[design/round_count_load_rebalancer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-count load rebalancer
// Counts finished rounds per worker in two banks and, when worker 0 reports
// while its bank is pending, re-sorts the workers and emits pairing moves.
// ----------------------------------------------------------------------------
// A round report that does not start a rebalance passes through the transfer
// and the count update, with the input ready again right after. A report that
// starts a rebalance keeps the input stalled while one sequencer walks the
// worker line (MAX_WORKERS entries): it fetches the counts through the single
// memory read port, makes bubble passes with the one comparator (at most the
// number of workers in use, fewer when the order is already nearly sorted),
// fills the pairing stack, tests each pair in the shift-and-add multiplier and
// restores the line. Reset and bank clears take no sweep, as every count entry
// carries a valid bit.
module round_count_load_rebalancer #(
   parameter int MAX_WORKERS = rclr_pkg::DEF_MAX_WORKERS,
   parameter int COUNT_BITS  = rclr_pkg::DEF_COUNT_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rclr_pkg::WORKER_BITS-1:0]    req_worker_id,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rclr_pkg::WORKER_BITS-1:0]    rsp_slow_worker,
   output logic [rclr_pkg::WORKER_BITS-1:0]    rsp_fast_worker,
   output logic                                rsp_last_move,
   input  logic                                csr_write_en,
   input  logic [rclr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rclr_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import rclr_pkg::*;

   localparam int ID_BITS   = $clog2(MAX_WORKERS);
   localparam int ADDR_BITS = ID_BITS + 1;
   localparam int POS_BITS  = $clog2(MAX_WORKERS + 1);
   localparam int CW        = (POS_BITS > NUM_WORKERS_BITS) ? POS_BITS : NUM_WORKERS_BITS;
   localparam int EXT_BITS  = (ID_BITS > WORKER_BITS) ? ID_BITS : WORKER_BITS;
   localparam int CMP_BITS  = (COUNT_BITS > PERIOD_BITS) ? COUNT_BITS : PERIOD_BITS;
   localparam logic [CW-1:0] LAST_POS = CW'(MAX_WORKERS);
   localparam logic [CW-1:0] END_POS  = CW'(MAX_WORKERS - 1);

   // Configuration
   logic [NUM_WORKERS_BITS-1:0] num_workers_ff, num_workers_in;
   logic [PERIOD_BITS-1:0]      round_period_ff, round_period_in;
   logic [RATIO_BITS-1:0]       diff_ratio_ff, diff_ratio_in;

   // Sequencer
   state_type                   state_ff, state_in;
   logic [CW-1:0]               pos_ff, pos_in;
   logic                        phase_ff, phase_in;
   logic                        swapped_ff, swapped_in;
   logic                        bank_ff, bank_in;
   logic                        old_bank_ff, old_bank_in;
   logic [1:0]                  pending_ff, pending_in;
   logic [ID_BITS-1:0]          worker_ff, worker_in;

   // Worker line (the worker order with fetched counts) and pairing stack
   logic [ID_BITS-1:0]          line_id_ff [MAX_WORKERS];
   logic [ID_BITS-1:0]          line_id_in [MAX_WORKERS];
   logic [COUNT_BITS-1:0]       line_key_ff [MAX_WORKERS];
   logic [COUNT_BITS-1:0]       line_key_in [MAX_WORKERS];
   logic [ID_BITS-1:0]          stk_id_ff [MAX_WORKERS];
   logic [ID_BITS-1:0]          stk_id_in [MAX_WORKERS];
   logic [COUNT_BITS-1:0]       stk_key_ff [MAX_WORKERS];
   logic [COUNT_BITS-1:0]       stk_key_in [MAX_WORKERS];

   // Held move and result register
   logic                        held_valid_ff, held_valid_in;
   logic [ID_BITS-1:0]          held_slow_ff, held_slow_in;
   logic [ID_BITS-1:0]          held_fast_ff, held_fast_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [WORKER_BITS-1:0]      rsp_slow_ff, rsp_slow_in;
   logic [WORKER_BITS-1:0]      rsp_fast_ff, rsp_fast_in;
   logic                        rsp_last_ff, rsp_last_in;

   // Control and datapath nets
   logic [NUM_WORKERS_BITS-1:0] active_n;
   logic [CW-1:0]               n_cw;
   logic [EXT_BITS-1:0]         req_id_ext;
   logic [ID_BITS-1:0]          req_id;
   logic                        req_fire;
   logic                        req_use;
   logic                        slot_free;
   logic                        pos_last;
   logic                        pos_end;
   logic [COUNT_BITS-1:0]       cnt_cur;
   logic [COUNT_BITS-1:0]       cnt_inc;
   logic                        cnt_sat;
   logic                        hit_period;
   logic                        go_rebal;
   logic                        sort_swap;
   logic                        pair_more;
   logic                        advance;
   logic                        rot_en;
   logic                        rot_keep;
   logic                        push_en;
   logic                        emit_mid;
   logic                        emit_last;
   logic [EXT_BITS-1:0]         held_slow_ext;
   logic [EXT_BITS-1:0]         held_fast_ext;
   logic                        mt_start;
   logic                        mt_done;
   logic                        mt_move;
   store_ctl_type               store_ctl;
   logic [ADDR_BITS-1:0]        rd_addr;
   logic [ADDR_BITS-1:0]        wr_addr;

   always_comb begin
      if (num_workers_ff < MIN_WORKERS) begin
         active_n = MIN_WORKERS;
      end else if (num_workers_ff > LIMIT_WORKERS) begin
         active_n = LIMIT_WORKERS;
      end else begin
         active_n = num_workers_ff;
      end
      if (CW'(active_n) > LAST_POS) begin
         active_n = NUM_WORKERS_BITS'(MAX_WORKERS);
      end
   end

   assign n_cw       = CW'(active_n);
   assign req_id_ext = EXT_BITS'(req_worker_id);
   assign req_id     = req_id_ext[ID_BITS-1:0];
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign req_use    = req_fire && (round_period_ff != '0) && (CW'(req_worker_id) < n_cw);
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign pos_last   = (pos_ff == LAST_POS);
   assign pos_end    = (pos_ff == END_POS);

   assign cnt_sat    = &cnt_cur;
   assign cnt_inc    = cnt_cur + COUNT_BITS'(1);
   assign hit_period = !cnt_sat && (CMP_BITS'(cnt_inc) == CMP_BITS'(round_period_ff));
   assign go_rebal   = (worker_ff == '0) && (pending_ff[bank_ff] || hit_period);
   assign sort_swap  = (pos_ff < n_cw) && (line_key_ff[0] > line_key_ff[1]);
   assign pair_more  = ({pos_ff, 1'b1} < {1'b0, n_cw});
   assign advance    = (state_ff == ST_DECIDE) && mt_move && (!held_valid_ff || slot_free);
   assign emit_mid   = advance && held_valid_ff;
   assign emit_last  = (state_ff == ST_FLUSH) && held_valid_ff && slot_free;
   assign mt_start   = (state_ff == ST_PAIR) && pair_more;

   assign rot_en   = ((state_ff == ST_LOAD) && phase_ff) || (state_ff == ST_SORT)
                     || (state_ff == ST_FILL) || advance
                     || ((state_ff == ST_UNROT) && !pos_last);
   assign rot_keep = (state_ff == ST_SORT) && !pos_last && sort_swap;
   assign push_en  = (state_ff == ST_FILL) && (pos_ff < n_cw);

   assign store_ctl.wr_en    = (state_ff == ST_INC) && !cnt_sat;
   assign store_ctl.clr_en   = (state_ff == ST_UNROT) && pos_last;
   assign store_ctl.clr_bank = old_bank_ff;
   assign wr_addr = {bank_ff, worker_ff};
   assign rd_addr = (state_ff == ST_IDLE) ? {bank_ff, req_id} : {old_bank_ff, line_id_ff[0]};

   assign held_slow_ext = EXT_BITS'(held_slow_ff);
   assign held_fast_ext = EXT_BITS'(held_fast_ff);

   rclr_count_store #(
      .MAX_WORKERS (MAX_WORKERS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (store_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (cnt_inc),
      .rd_data (cnt_cur)
   );

   rclr_move_test #(
      .COUNT_BITS (COUNT_BITS)
   ) u_move_test (
      .clock (clock),
      .reset (reset),
      .start (mt_start),
      .slow  (line_key_ff[0]),
      .fast  (stk_key_ff[0]),
      .ratio (diff_ratio_ff),
      .done  (mt_done),
      .move  (mt_move)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_use) begin
               state_in = ST_INC;
            end
         end
         ST_INC: begin
            state_in = go_rebal ? ST_LOAD : ST_IDLE;
         end
         ST_LOAD: begin
            if (phase_ff && pos_end) begin
               state_in = ST_SORT;
            end
         end
         ST_SORT: begin
            if (pos_last && !swapped_ff) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (pos_end) begin
               state_in = ST_PAIR;
            end
         end
         ST_PAIR: begin
            state_in = pair_more ? ST_MUL : ST_FLUSH;
         end
         ST_MUL: begin
            if (mt_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!mt_move) begin
               state_in = ST_FLUSH;
            end else if (advance) begin
               state_in = ST_PAIR;
            end
         end
         ST_FLUSH: begin
            if (!held_valid_ff || slot_free) begin
               state_in = ST_UNROT;
            end
         end
         ST_UNROT: begin
            if (pos_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs and datapath updates
   always_comb begin
      num_workers_in  = num_workers_ff;
      round_period_in = round_period_ff;
      diff_ratio_in   = diff_ratio_ff;
      pos_in          = pos_ff;
      phase_in        = phase_ff;
      swapped_in      = swapped_ff;
      bank_in         = bank_ff;
      old_bank_in     = old_bank_ff;
      pending_in      = pending_ff;
      worker_in       = worker_ff;
      held_valid_in   = held_valid_ff;
      held_slow_in    = held_slow_ff;
      held_fast_in    = held_fast_ff;
      rsp_slow_in     = rsp_slow_ff;
      rsp_fast_in     = rsp_fast_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      line_id_in      = line_id_ff;
      line_key_in     = line_key_ff;
      stk_id_in       = stk_id_ff;
      stk_key_in      = stk_key_ff;

      if (req_fire) begin
         worker_in = req_id;
      end

      unique case (state_ff)
         ST_INC: begin
            if (hit_period) begin
               pending_in[bank_ff] = 1'b1;
            end
            if (go_rebal) begin
               bank_in     = !bank_ff;
               old_bank_in = bank_ff;
               pos_in      = '0;
               phase_in    = 1'b0;
            end
         end
         ST_LOAD: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               if (pos_end) begin
                  pos_in     = CW'(1);
                  swapped_in = 1'b0;
               end else begin
                  pos_in = pos_ff + CW'(1);
               end
            end
         end
         ST_SORT: begin
            if (pos_last) begin
               pos_in     = swapped_ff ? CW'(1) : '0;
               swapped_in = 1'b0;
            end else begin
               pos_in     = pos_ff + CW'(1);
               swapped_in = swapped_ff || sort_swap;
            end
         end
         ST_FILL: begin
            pos_in = pos_end ? '0 : pos_ff + CW'(1);
         end
         ST_DECIDE: begin
            if (advance) begin
               pos_in        = pos_ff + CW'(1);
               held_valid_in = 1'b1;
               held_slow_in  = line_id_ff[0];
               held_fast_in  = stk_id_ff[0];
            end
         end
         ST_FLUSH: begin
            if (emit_last) begin
               held_valid_in = 1'b0;
            end
         end
         ST_UNROT: begin
            if (pos_last) begin
               pending_in[old_bank_ff] = 1'b0;
            end else begin
               pos_in = pos_ff + CW'(1);
            end
         end
         default: begin
         end
      endcase

      if (emit_mid || emit_last) begin
         rsp_valid_in = 1'b1;
         rsp_slow_in  = held_slow_ext[WORKER_BITS-1:0];
         rsp_fast_in  = held_fast_ext[WORKER_BITS-1:0];
         rsp_last_in  = emit_last;
      end

      // The line rotates towards the head; a sort step that finds the head
      // larger keeps it as the carried element and sends the next one back.
      if (rot_en) begin
         for (int k = 0; k < MAX_WORKERS - 1; k++) begin
            line_id_in[k]  = line_id_ff[k + 1];
            line_key_in[k] = line_key_ff[k + 1];
         end
         line_id_in[MAX_WORKERS-1]  = line_id_ff[0];
         line_key_in[MAX_WORKERS-1] = (state_ff == ST_LOAD) ? cnt_cur : line_key_ff[0];
         if (rot_keep) begin
            line_id_in[0]              = line_id_ff[0];
            line_key_in[0]             = line_key_ff[0];
            line_id_in[MAX_WORKERS-1]  = line_id_ff[1];
            line_key_in[MAX_WORKERS-1] = line_key_ff[1];
         end
      end

      if (push_en) begin
         for (int k = 1; k < MAX_WORKERS; k++) begin
            stk_id_in[k]  = stk_id_ff[k - 1];
            stk_key_in[k] = stk_key_ff[k - 1];
         end
         stk_id_in[0]  = line_id_ff[0];
         stk_key_in[0] = line_key_ff[0];
      end else if (advance) begin
         for (int k = 0; k < MAX_WORKERS - 1; k++) begin
            stk_id_in[k]  = stk_id_ff[k + 1];
            stk_key_in[k] = stk_key_ff[k + 1];
         end
      end

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_NUM_WORKERS: begin
               num_workers_in = csr_wdata[NUM_WORKERS_BITS-1:0];
               for (int k = 0; k < MAX_WORKERS; k++) begin
                  line_id_in[k] = ID_BITS'(k);
               end
            end
            CSR_ROUND_PERIOD: begin
               round_period_in = csr_wdata[PERIOD_BITS-1:0];
            end
            CSR_DIFF_RATIO: begin
               diff_ratio_in = csr_wdata[RATIO_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_workers_ff  <= NUM_WORKERS_RESET;
         round_period_ff <= ROUND_PERIOD_RESET;
         diff_ratio_ff   <= DIFF_RATIO_RESET;
         state_ff        <= ST_IDLE;
         pos_ff          <= '0;
         phase_ff        <= 1'b0;
         swapped_ff      <= 1'b0;
         bank_ff         <= 1'b0;
         old_bank_ff     <= 1'b0;
         pending_ff      <= '0;
         held_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         for (int k = 0; k < MAX_WORKERS; k++) begin
            line_id_ff[k] <= ID_BITS'(k);
         end
      end else begin
         num_workers_ff  <= num_workers_in;
         round_period_ff <= round_period_in;
         diff_ratio_ff   <= diff_ratio_in;
         state_ff        <= state_in;
         pos_ff          <= pos_in;
         phase_ff        <= phase_in;
         swapped_ff      <= swapped_in;
         bank_ff         <= bank_in;
         old_bank_ff     <= old_bank_in;
         pending_ff      <= pending_in;
         held_valid_ff   <= held_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         line_id_ff      <= line_id_in;
      end
      worker_ff    <= worker_in;
      held_slow_ff <= held_slow_in;
      held_fast_ff <= held_fast_in;
      rsp_slow_ff  <= rsp_slow_in;
      rsp_fast_ff  <= rsp_fast_in;
      rsp_last_ff  <= rsp_last_in;
      line_key_ff  <= line_key_in;
      stk_id_ff    <= stk_id_in;
      stk_key_ff   <= stk_key_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slow_worker = rsp_slow_ff;
   assign rsp_fast_worker = rsp_fast_ff;
   assign rsp_last_move   = rsp_last_ff;

   a_idle_nothing_held : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !held_valid_ff)
      else $error("a move is still held after the rebalance ended");

   a_position_in_range : assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_POS)
      else $error("line position beyond the line length");

   a_old_bank_released : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_UNROT) && pos_last) |=> !pending_ff[old_bank_ff])
      else $error("old bank still pending after the rebalance");

   a_update_follows_transfer : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INC) |-> $past(req_valid && req_ready))
      else $error("count update without an input transfer");

endmodule

[design/rclr_count_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round count store
// Two banks of per-worker round counts in one memory with a registered read
// port, plus a valid bit per entry so that reset and bank clears are instant.
// ----------------------------------------------------------------------------
module rclr_count_store #(
   parameter int MAX_WORKERS = rclr_pkg::DEF_MAX_WORKERS,
   parameter int COUNT_BITS  = rclr_pkg::DEF_COUNT_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rclr_pkg::store_ctl_type             ctl,
   input  logic [$clog2(MAX_WORKERS):0]        rd_addr,
   input  logic [$clog2(MAX_WORKERS):0]        wr_addr,
   input  logic [COUNT_BITS-1:0]               wr_data,
   output logic [COUNT_BITS-1:0]               rd_data
);
   import rclr_pkg::*;

   localparam int ID_BITS   = $clog2(MAX_WORKERS);
   localparam int ADDR_BITS = ID_BITS + 1;
   localparam int DEPTH     = 2 ** ADDR_BITS;

   logic [COUNT_BITS-1:0] mem [DEPTH];
   logic [DEPTH-1:0]      valid_ff;
   logic [DEPTH-1:0]      valid_in;
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      if (ctl.clr_en) begin
         for (int k = 0; k < 2 ** ID_BITS; k++) begin
            valid_in[{ctl.clr_bank, ID_BITS'(k)}] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

   a_no_write_during_clear : assert property (@(posedge clock) disable iff (reset)
      !(ctl.wr_en && ctl.clr_en))
      else $error("count store written and cleared in the same cycle");

   a_write_marks_valid : assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en |=> valid_ff[$past(wr_addr)])
      else $error("written count entry not marked valid");

   a_clear_drops_bank : assert property (@(posedge clock) disable iff (reset)
      ctl.clr_en |=> !valid_ff[{$past(ctl.clr_bank), ID_BITS'(0)}])
      else $error("cleared bank still holds a valid entry");

endmodule

[design/rclr_move_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move test unit
// Decides whether a slow and fast pair is unbalanced: 256*(fast-slow) is
// compared with diff_ratio*slow, the product formed by a shift-and-add loop.
// ----------------------------------------------------------------------------
module rclr_move_test #(
   parameter int COUNT_BITS = rclr_pkg::DEF_COUNT_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [COUNT_BITS-1:0]           slow,
   input  logic [COUNT_BITS-1:0]           fast,
   input  logic [rclr_pkg::RATIO_BITS-1:0] ratio,
   output logic                            done,
   output logic                            move
);
   import rclr_pkg::*;

   localparam int ACC_BITS = COUNT_BITS + RATIO_BITS;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  move_ff, move_in;
   logic                  zero_ratio_ff, zero_ratio_in;
   logic [RATIO_BITS-1:0] ratio_ff, ratio_in;
   logic [ACC_BITS-1:0]   addend_ff, addend_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [COUNT_BITS-1:0] diff_ff, diff_in;
   logic [ACC_BITS-1:0]   diff_scaled;

   assign diff_scaled = ACC_BITS'({diff_ff, {RATIO_FRAC_BITS{1'b0}}});

   always_comb begin
      busy_in       = busy_ff;
      done_in       = 1'b0;
      move_in       = move_ff;
      zero_ratio_in = zero_ratio_ff;
      ratio_in      = ratio_ff;
      addend_in     = addend_ff;
      acc_in        = acc_ff;
      diff_in       = diff_ff;
      if (start) begin
         busy_in       = 1'b1;
         zero_ratio_in = (ratio == '0);
         ratio_in      = ratio;
         addend_in     = ACC_BITS'(slow);
         acc_in        = '0;
         diff_in       = fast - slow;
      end else if (busy_ff) begin
         if (ratio_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            move_in = zero_ratio_ff || (diff_scaled > acc_ff);
         end else begin
            if (ratio_ff[0]) begin
               acc_in = acc_ff + addend_ff;
            end
            addend_in = addend_ff << 1;
            ratio_in  = ratio_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         move_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         move_ff <= move_in;
      end
      zero_ratio_ff <= zero_ratio_in;
      ratio_ff      <= ratio_in;
      addend_ff     <= addend_in;
      acc_ff        <= acc_in;
      diff_ff       <= diff_in;
   end

   assign done = done_ff;
   assign move = move_ff;

   a_done_when_free : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("move test reports done while still busy");

   a_start_runs : assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("move test did not start");

   a_zero_ratio_moves : assert property (@(posedge clock) disable iff (reset)
      (done_ff && zero_ratio_ff) |-> move_ff)
      else $error("zero ratio must always move");

endmodule

[sim/tb_round_count_load_rebalancer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-count load rebalancer testbench
// Feeds round reports through the request channel and checks every move that
// leaves the response channel against a cycle-free model of the counting
// banks, the stable re-sort and the pairing rule. A short table of directed
// rows comes first, followed by random phases that each pick a new register
// setting. Both channels idle and stall at random throughout.
// ----------------------------------------------------------------------------
module tb_round_count_load_rebalancer;
   import rclr_pkg::*;

   localparam int MAX_W = DEF_MAX_WORKERS;
   localparam int CNT_W = DEF_COUNT_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 800;
   localparam int TARGET_ROUNDS = 230;
   localparam int TARGET_MOVES  = 60;
   localparam int MAX_SENT      = 700;
   localparam int NUM_ROWS      = 30;

   typedef struct packed {
      logic [WORKER_BITS-1:0] slow;
      logic [WORKER_BITS-1:0] fast;
      logic                   last;
   } move_t;

   typedef enum logic {ROW_ROUND, ROW_CSR} row_kind_t;

   typedef struct packed {
      row_kind_t                 kind;
      logic [CSR_INDEX_BITS-1:0] reg_index;
      logic [CSR_DATA_BITS-1:0]  data;
      logic [WORKER_BITS-1:0]    worker;
      logic                      typed;
      logic                      has_move;
      move_t                     move;
   } stim_row_t;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_SPARSE} rx_mode_t;

   // Rows marked typed carry their expected outcome; the others use the model.
   stim_row_t directed_rows [NUM_ROWS] = '{
      '{ROW_ROUND, '0, '0, 4'd0,  1'b1, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_ROUND, '0, '0, 4'd15, 1'b1, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_CSR, CSR_ROUND_PERIOD, 16'd1, '0, 1'b0, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_ROUND, '0, '0, 4'd1,  1'b1, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_ROUND, '0, '0, 4'd0,  1'b1, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_CSR, CSR_DIFF_RATIO, 16'd0, '0, 1'b0, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_ROUND, '0, '0, 4'd0,  1'b1, 1'b1, '{4'd1, 4'd0, 1'b1}},
      '{ROW_ROUND, '0, '0, 4'd2,  1'b1, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_CSR, CSR_NUM_WORKERS, 16'd16, '0, 1'b0, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_CSR, CSR_DIFF_RATIO, 16'hFFFF, '0, 1'b0, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_ROUND, '0, '0, 4'd15, 1'b0, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_ROUND, '0, '0, 4'd15, 1'b0, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_ROUND, '0, '0, 4'd0,  1'b0, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_CSR, CSR_DIFF_RATIO, 16'd0, '0, 1'b0, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_ROUND, '0, '0, 4'd0,  1'b0, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_CSR, CSR_NUM_WORKERS, 16'd0, '0, 1'b0, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_ROUND, '0, '0, 4'd2,  1'b1, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_CSR, CSR_NUM_WORKERS, 16'hFFFF, '0, 1'b0, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_ROUND, '0, '0, 4'd15, 1'b1, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_CSR, CSR_SPARE, 16'hFFFF, '0, 1'b0, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_CSR, CSR_ROUND_PERIOD, 16'hFFFF, '0, 1'b0, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_ROUND, '0, '0, 4'd0,  1'b0, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_ROUND, '0, '0, 4'd5,  1'b1, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_CSR, CSR_ROUND_PERIOD, 16'd2, '0, 1'b0, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_CSR, CSR_DIFF_RATIO, 16'h0180, '0, 1'b0, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_ROUND, '0, '0, 4'd3,  1'b1, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_ROUND, '0, '0, 4'd3,  1'b1, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_ROUND, '0, '0, 4'd4,  1'b1, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_ROUND, '0, '0, 4'd10, 1'b1, 1'b0, '{4'd0, 4'd0, 1'b0}},
      '{ROW_ROUND, '0, '0, 4'd0,  1'b0, 1'b0, '{4'd0, 4'd0, 1'b0}}
   };

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [WORKER_BITS-1:0]      req_worker_id;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [WORKER_BITS-1:0]      rsp_slow_worker;
   logic [WORKER_BITS-1:0]      rsp_fast_worker;
   logic                        rsp_last_move;
   logic                        csr_write_en;
   logic [CSR_INDEX_BITS-1:0]   csr_index;
   logic [CSR_DATA_BITS-1:0]    csr_wdata;

   // Model state
   logic [NUM_WORKERS_BITS-1:0] cfg_workers;
   logic [PERIOD_BITS-1:0]      cfg_period;
   logic [RATIO_BITS-1:0]       cfg_ratio;
   logic [CNT_W-1:0]            tally [2][MAX_W];
   logic                        tally_bank;
   logic                        bank_pending [2];
   logic [WORKER_BITS-1:0]      line_order [MAX_W];

   move_t    fresh_moves[$];
   move_t    expected_moves[$];
   int       error_count = 0;
   int       moves_expected = 0;
   int       rounds_counted = 0;
   int       rounds_sent = 0;
   int       burst_left = 1;
   logic     lines_dirty = 1'b0;
   rx_mode_t stall_mode = RX_OPEN;
   int       stall_phase = 0;

   round_count_load_rebalancer i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_worker_id   (req_worker_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_slow_worker (rsp_slow_worker),
      .rsp_fast_worker (rsp_fast_worker),
      .rsp_last_move   (rsp_last_move),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic int clamped_workers();
      int n;
      n = cfg_workers;
      if (n < MIN_WORKERS) n = MIN_WORKERS;
      if (n > LIMIT_WORKERS) n = LIMIT_WORKERS;
      if (n > MAX_W) n = MAX_W;
      return n;
   endfunction

   function automatic void restore_order();
      for (int k = 0; k < MAX_W; k++) line_order[k] = WORKER_BITS'(k);
   endfunction

   function automatic void clear_model();
      cfg_workers = NUM_WORKERS_RESET;
      cfg_period  = ROUND_PERIOD_RESET;
      cfg_ratio   = DIFF_RATIO_RESET;
      for (int b = 0; b < 2; b++) begin
         bank_pending[b] = 1'b0;
         for (int k = 0; k < MAX_W; k++) tally[b][k] = '0;
      end
      tally_bank = 1'b0;
      restore_order();
   endfunction

   function automatic void apply_csr(logic [CSR_INDEX_BITS-1:0] reg_index,
                                     logic [CSR_DATA_BITS-1:0] data);
      case (reg_index)
         CSR_NUM_WORKERS: begin
            cfg_workers = data[NUM_WORKERS_BITS-1:0];
            restore_order();
         end
         CSR_ROUND_PERIOD: cfg_period = data[PERIOD_BITS-1:0];
         CSR_DIFF_RATIO:   cfg_ratio = data[RATIO_BITS-1:0];
         default: ;
      endcase
   endfunction

   // The pair moves when the ratio is zero or 256 * (fast - slow) exceeds ratio * slow, exactly.
   function automatic logic worth_moving(logic [CNT_W-1:0] slow, logic [CNT_W-1:0] fast);
      logic [63:0] lhs;
      logic [63:0] rhs;
      if (cfg_ratio == '0) return 1'b1;
      lhs = 64'(fast - slow) << RATIO_FRAC_BITS;
      rhs = 64'(cfg_ratio) * 64'(slow);
      return lhs > rhs;
   endfunction

   // Counts one round and fills fresh_moves; returns whether the round counted.
   function automatic logic account_round(logic [WORKER_BITS-1:0] w);
      int n;
      int i;
      int j;
      logic b;
      logic [WORKER_BITS-1:0] v;
      logic [WORKER_BITS-1:0] si;
      logic [WORKER_BITS-1:0] fi;
      move_t m;
      fresh_moves.delete();
      n = clamped_workers();
      if (cfg_period == '0 || int'(w) >= n) return 1'b0;
      b = tally_bank;
      if (tally[b][w] != '1) begin
         tally[b][w] = tally[b][w] + 1'b1;
         if (tally[b][w] == CNT_W'(cfg_period)) bank_pending[b] = 1'b1;
      end
      if (w != '0 || !bank_pending[b]) return 1'b1;
      tally_bank = ~b;
      for (i = 1; i < n; i++) begin
         v = line_order[i];
         j = i;
         while (j > 0 && tally[b][line_order[j-1]] > tally[b][v]) begin
            line_order[j] = line_order[j-1];
            j--;
         end
         line_order[j] = v;
      end
      i = 0;
      j = n - 1;
      while (i < j) begin
         si = line_order[i];
         fi = line_order[j];
         if (!worth_moving(tally[b][si], tally[b][fi])) break;
         m.slow = si;
         m.fast = fi;
         m.last = 1'b0;
         fresh_moves.push_back(m);
         i++;
         j--;
      end
      if (fresh_moves.size() > 0) begin
         m = fresh_moves.pop_back();
         m.last = 1'b1;
         fresh_moves.push_back(m);
      end
      for (i = 0; i < MAX_W; i++) tally[b][i] = '0;
      bank_pending[b] = 1'b0;
      return 1'b1;
   endfunction

   function automatic void report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      error_count++;
   endfunction

   function automatic void compare_field(string name, int got, int want);
      if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endfunction

   always @(posedge clock) begin
      move_t got;
      move_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.slow = rsp_slow_worker;
         got.fast = rsp_fast_worker;
         got.last = rsp_last_move;
         if (expected_moves.size() == 0) begin
            report_mismatch($sformatf("move %0d to %0d with none expected",
                                      got.slow, got.fast));
         end else begin
            want = expected_moves.pop_front();
            compare_field("slow_worker", got.slow, want.slow);
            compare_field("fast_worker", got.fast, want.fast);
            compare_field("last_move", got.last, want.last);
         end
      end
   end

   always @(posedge clock) begin
      if (stall_phase == 0) begin
         stall_mode  <= rx_mode_t'($urandom_range(0, 3));
         stall_phase <= $urandom_range(16, 96);
      end else begin
         stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
         RX_OPEN:         rsp_ready <= 1'b1;
         RX_COIN:         rsp_ready <= 1'($urandom_range(0, 1));
         RX_EVERY_FOURTH: rsp_ready <= (stall_phase % 4 == 0);
         default:         rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic send_round(input logic [WORKER_BITS-1:0] w, input logic typed,
                             input logic has_move, input move_t typed_move);
      int gap;
      req_valid     <= 1'b1;
      req_worker_id <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      rounds_sent++;
      if (account_round(w)) rounds_counted++;
      if (typed) begin
         if (has_move) begin
            expected_moves.push_back(typed_move);
            moves_expected++;
         end
      end else begin
         foreach (fresh_moves[k]) expected_moves.push_back(fresh_moves[k]);
         moves_expected += fresh_moves.size();
      end
      lines_dirty = 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drains all expected moves, then lets the sequencer finish restoring its line.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_moves.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      lines_dirty = 1'b0;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] reg_index,
                            input logic [CSR_DATA_BITS-1:0] data);
      if (lines_dirty) settle();
      csr_write_en <= 1'b1;
      csr_index    <= reg_index;
      csr_wdata    <= data;
      @(posedge clock);
      apply_csr(reg_index, data);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      stim_row_t row;
      move_t none;
      int span;
      int r;
      logic [WORKER_BITS-1:0] w;
      logic [RATIO_BITS-1:0] ratio;
      none          = '0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_worker_id <= '0;
      csr_write_en  <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      clear_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int k = 0; k < NUM_ROWS; k++) begin
         row = directed_rows[k];
         if (row.kind == ROW_CSR) write_csr(row.reg_index, row.data);
         else send_round(row.worker, row.typed, row.has_move, row.move);
      end

      while ((rounds_counted < TARGET_ROUNDS || moves_expected < TARGET_MOVES)
             && rounds_sent < MAX_SENT) begin
         if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 5))
               0:       span = LIMIT_WORKERS;
               1:       span = MIN_WORKERS;
               5:       span = $urandom_range(0, 31);
               default: span = $urandom_range(MIN_WORKERS, LIMIT_WORKERS);
            endcase
            write_csr(CSR_NUM_WORKERS, {11'($urandom), 5'(span)});
         end
         if ($urandom_range(0, 9) < 8) begin
            case ($urandom_range(0, 9))
               0:       span = 0;
               1:       span = $urandom_range(5, 12);
               default: span = $urandom_range(1, 4);
            endcase
            write_csr(CSR_ROUND_PERIOD, CSR_DATA_BITS'(span));
         end
         case ($urandom_range(0, 7))
            0:       ratio = '0;
            1:       ratio = '1;
            2:       ratio = 16'd256;
            3:       ratio = RATIO_BITS'($urandom);
            default: ratio = RATIO_BITS'($urandom_range(64, 1024));
         endcase
         write_csr(CSR_DIFF_RATIO, ratio);
         if ($urandom_range(0, 9) == 0) write_csr(CSR_SPARE, CSR_DATA_BITS'($urandom));

         span = (cfg_period == '0) ? 6 : $urandom_range(15, 40);
         repeat (span) begin
            r = $urandom_range(0, 9);
            if (r < 2) w = '0;
            else if (r < 8) w = WORKER_BITS'($urandom_range(0, clamped_workers() - 1));
            else w = WORKER_BITS'($urandom_range(0, MAX_W - 1));
            send_round(w, 1'b0, 1'b0, none);
         end
      end

      settle();
      if (error_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
